/* design/scfp_pkg.sv */
package scfp_pkg;

  localparam int CLASS_COUNT = 9;
  localparam int CLASS1_MULT = 3;
  // Widest slot number over the whole parameter range (three times 65536 slots)
  localparam int SLOT_MAX_W  = 18;
  localparam int XW          = 32;

  // Request types
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_GRANTED   = 3'd0;
  localparam logic [2:0] ACT_SYSTEM    = 3'd1;
  localparam logic [2:0] ACT_KEPT      = 3'd2;
  localparam logic [2:0] ACT_MOVE      = 3'd3;
  localparam logic [2:0] ACT_RELEASED  = 3'd4;
  localparam logic [2:0] ACT_EXHAUSTED = 3'd5;
  localparam logic [2:0] ACT_UNDERFLOW = 3'd6;

  // Command kinds passed from front to back
  localparam logic [1:0] CK_SYS     = 2'd0;
  localparam logic [1:0] CK_ALLOC   = 2'd1;
  localparam logic [1:0] CK_FREE    = 2'd2;
  localparam logic [1:0] CK_REALLOC = 2'd3;

  // Config register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_BYPASS = 2'd1;
  localparam logic [1:0] CFG_BASE   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] request_size;
    logic [63:0] block_address;
    logic        caller_eligible;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] granted_address;
    logic [3:0]  class_index;
    logic [9:0]  slot_index;
    logic [10:0] copy_bytes;
  } out_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [3:0]            cls;
    logic [SLOT_MAX_W-1:0] slot;
    logic                  fits;
    logic [63:0]           addr;
  } cmd_t;

  localparam logic [10:0] CLS_BYTES [CLASS_COUNT] =
    '{11'd40, 11'd48, 11'd128, 11'd256, 11'd296, 11'd1024, 11'd1168, 11'd56, 11'd784};

  // Class size = odd factor << shift
  localparam logic [3:0] CLS_SHIFT [CLASS_COUNT] =
    '{4'd3, 4'd4, 4'd7, 4'd8, 4'd3, 4'd10, 4'd4, 4'd3, 4'd4};
  localparam logic [6:0] CLS_ODD [CLASS_COUNT] =
    '{7'd5, 7'd3, 7'd1, 7'd1, 7'd37, 7'd1, 7'd73, 7'd7, 7'd49};
  // floor(2^32 / odd factor)
  localparam logic [32:0] CLS_RECIP [CLASS_COUNT] =
    '{33'd858993459, 33'd1431655765, 33'd4294967296, 33'd4294967296, 33'd116080197,
      33'd4294967296, 33'd58835168, 33'd613566756, 33'd87652393};

  function automatic int unsigned cls_len(input int k, input int unsigned s);
    if (k == 1) return CLASS1_MULT * s;
    if (k >= 7) return 1;
    return s;
  endfunction

  function automatic longint unsigned region_bytes(input int k, input int unsigned s);
    return longint'(cls_len(k, s)) * longint'(CLS_BYTES[k]);
  endfunction

  // Byte offset of a class region from the pool base
  function automatic longint unsigned region_off(input int k, input int unsigned s);
    longint unsigned acc;
    acc = 0;
    for (int i = 0; i < CLASS_COUNT; i++) begin
      if (i < k) acc += region_bytes(i, s);
    end
    return acc;
  endfunction

  // First ring entry of a class
  function automatic int unsigned ring_start(input int k, input int unsigned s);
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < CLASS_COUNT; i++) begin
      if (i < k) acc += cls_len(i, s);
    end
    return acc;
  endfunction

endpackage

/* design/scfp_ram.sv */
module scfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* design/scfp_front.sv */
module scfp_front #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scfp_pkg::in_t       in_data,
  input  logic                pool_enable,
  input  logic                pool_bypass,
  input  logic [63:0]         pool_base,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output scfp_pkg::cmd_t      cmd
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_FIX  = 2'd2;

  logic [1:0]            state;
  scfp_pkg::cmd_t        cmd_r;
  scfp_pkg::cmd_t        cmd_new;
  logic [scfp_pkg::XW-1:0] x;
  logic [scfp_pkg::XW-1:0] x_new;
  logic [scfp_pkg::XW-1:0] q0;
  logic                  need_div;

  logic [63:0] off_a [scfp_pkg::CLASS_COUNT];
  logic [scfp_pkg::CLASS_COUNT-1:0] hit;
  logic        found;
  logic        matched;
  logic [3:0]  sel;
  logic [3:0]  msel;
  logic [63:0] sel_off;
  logic [64:0] prod;
  logic [scfp_pkg::XW-1:0] rem;
  logic [scfp_pkg::XW-1:0] q;

  // Classify the incoming request
  always_comb begin
    found   = 1'b0;
    matched = 1'b0;
    sel     = '0;
    msel    = '0;
    sel_off = '0;
    for (int k = 0; k < scfp_pkg::CLASS_COUNT; k++) begin
      off_a[k] = in_data.block_address - pool_base - scfp_pkg::region_off(k, SLOTS_PER_CLASS);
      hit[k]   = off_a[k] < scfp_pkg::region_bytes(k, SLOTS_PER_CLASS);
    end
    for (int k = 0; k < scfp_pkg::CLASS_COUNT; k++) begin
      if (hit[k] && !found) begin
        found   = 1'b1;
        sel     = 4'(k);
        sel_off = off_a[k];
      end
      if (in_data.request_size == {21'd0, scfp_pkg::CLS_BYTES[k]} && !matched) begin
        matched = 1'b1;
        msel    = 4'(k);
      end
    end
    x_new = sel_off[scfp_pkg::XW-1:0] >> scfp_pkg::CLS_SHIFT[sel];

    cmd_new      = '0;
    cmd_new.kind = scfp_pkg::CK_SYS;
    cmd_new.addr = in_data.block_address;
    unique case (in_data.req_type)
      scfp_pkg::REQ_ALLOC: begin
        if (pool_enable && !pool_bypass && in_data.caller_eligible && matched) begin
          cmd_new.kind = scfp_pkg::CK_ALLOC;
          cmd_new.cls  = msel;
        end
      end
      scfp_pkg::REQ_FREE, scfp_pkg::REQ_REALLOC: begin
        if (found) begin
          cmd_new.kind = (in_data.req_type == scfp_pkg::REQ_FREE) ?
                         scfp_pkg::CK_FREE : scfp_pkg::CK_REALLOC;
          cmd_new.cls  = sel;
          cmd_new.fits = in_data.request_size <= {21'd0, scfp_pkg::CLS_BYTES[sel]};
        end
      end
      default: cmd_new.kind = scfp_pkg::CK_SYS;
    endcase
  end

  // Divide the scaled offset by the odd factor: reciprocal estimate, then one correction
  assign prod = 65'(x) * 65'(scfp_pkg::CLS_RECIP[cmd_r.cls]);
  assign rem  = x - q0 * scfp_pkg::XW'(scfp_pkg::CLS_ODD[cmd_r.cls]);
  assign q    = (rem >= scfp_pkg::XW'(scfp_pkg::CLS_ODD[cmd_r.cls])) ? q0 + 1'b1 : q0;

  assign in_ready  = (state == F_IDLE);
  assign cmd_valid = (state == F_FIX);
  always_comb begin
    cmd      = cmd_r;
    cmd.slot = need_div ? q[scfp_pkg::SLOT_MAX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd_new;
            x        <= x_new;
            need_div <= (cmd_new.kind == scfp_pkg::CK_FREE) ||
                        (cmd_new.kind == scfp_pkg::CK_REALLOC);
            state    <= ((cmd_new.kind == scfp_pkg::CK_FREE) ||
                         (cmd_new.kind == scfp_pkg::CK_REALLOC)) ? F_DIV : F_FIX;
          end
        end
        F_DIV: begin
          q0    <= prod[63:32];
          state <= F_FIX;
        end
        F_FIX: begin
          if (cmd_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* design/scfp_fifo.sv */
module scfp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  scfp_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output scfp_pkg::cmd_t rd_data
);

  scfp_pkg::cmd_t entry [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/scfp_back.sv */
module scfp_back #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  scfp_pkg::cmd_t      cmd,
  input  logic [63:0]         pool_base,
  output logic                out_valid,
  input  logic                out_ready,
  output scfp_pkg::out_t      out_data
);

  localparam int SL_W       = $clog2(scfp_pkg::CLASS1_MULT * SLOTS_PER_CLASS);
  localparam int CNT_W      = $clog2(scfp_pkg::CLASS1_MULT * SLOTS_PER_CLASS + 1);
  // Six full-size classes, the enlarged class 1 and two single-slot classes
  localparam int RING_DEPTH = (6 + scfp_pkg::CLASS1_MULT) * SLOTS_PER_CLASS + 2;
  localparam int RA_W       = $clog2(RING_DEPTH);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_READ = 1'b1;

  logic             state;
  logic [SL_W-1:0]  head    [scfp_pkg::CLASS_COUNT];
  logic [SL_W-1:0]  tail    [scfp_pkg::CLASS_COUNT];
  logic [CNT_W-1:0] live    [scfp_pkg::CLASS_COUNT];
  logic [scfp_pkg::CLASS_COUNT-1:0] wrapped;

  logic [3:0]       rd_cls;
  logic [SL_W-1:0]  rd_head;
  logic             rd_hit;

  logic             out_free;
  logic             fire;
  logic [3:0]       k;
  logic [CNT_W-1:0] len_k;
  logic [SL_W-1:0]  h;
  logic [SL_W-1:0]  t;
  logic [CNT_W-1:0] lv;
  logic [SL_W-1:0]  cslot;
  logic             load;
  scfp_pkg::out_t   res;

  logic             mem_we;
  logic [RA_W-1:0]  mem_waddr;
  logic             mem_re;
  logic [RA_W-1:0]  mem_raddr;
  logic [SL_W-1:0]  mem_rdata;

  logic [SL_W-1:0]  gslot;
  logic [SL_W+10:0] gprod;
  logic [SL_W+9:0]  cslot_x;
  logic [SL_W+9:0]  gslot_x;
  logic             alloc_ok;
  logic             push_ok;
  logic             kept;

  scfp_ram #(.WIDTH(SL_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cslot),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == B_IDLE) && out_free;
  assign fire      = cmd_valid && cmd_ready;

  assign k     = cmd.cls;
  assign len_k = CNT_W'(scfp_pkg::cls_len(int'(k), SLOTS_PER_CLASS));
  assign h     = head[k];
  assign t     = tail[k];
  assign lv    = live[k];
  assign cslot = cmd.slot[SL_W-1:0];

  assign alloc_ok = (cmd.kind == scfp_pkg::CK_ALLOC) && (lv < len_k);
  assign kept     = (cmd.kind == scfp_pkg::CK_REALLOC) && cmd.fits;
  assign push_ok  = ((cmd.kind == scfp_pkg::CK_FREE) || (cmd.kind == scfp_pkg::CK_REALLOC)) &&
                    !kept && (lv != '0);

  // Entries never written since reset read as their identity value (the head position)
  assign gslot   = rd_hit ? mem_rdata : rd_head;
  assign gprod   = (SL_W+11)'(gslot) * (SL_W+11)'(scfp_pkg::CLS_BYTES[rd_cls]);
  assign cslot_x = (SL_W+10)'(cslot);
  assign gslot_x = (SL_W+10)'(gslot);

  // Decide the result and the ring access
  always_comb begin
    load      = 1'b0;
    res       = '0;
    res.action = scfp_pkg::ACT_SYSTEM;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = RA_W'(scfp_pkg::ring_start(int'(k), SLOTS_PER_CLASS)) + RA_W'(t);
    mem_raddr = RA_W'(scfp_pkg::ring_start(int'(k), SLOTS_PER_CLASS)) + RA_W'(h);
    unique case (state)
      B_IDLE: begin
        if (fire) begin
          case (cmd.kind)
            scfp_pkg::CK_ALLOC: begin
              if (alloc_ok) begin
                mem_re = 1'b1;
              end else begin
                load            = 1'b1;
                res.action      = scfp_pkg::ACT_EXHAUSTED;
                res.class_index = k;
              end
            end
            scfp_pkg::CK_FREE, scfp_pkg::CK_REALLOC: begin
              load            = 1'b1;
              res.class_index = k;
              res.slot_index  = cslot_x[9:0];
              if (kept) begin
                res.action          = scfp_pkg::ACT_KEPT;
                res.granted_address = cmd.addr;
              end else if (!push_ok) begin
                res.action = scfp_pkg::ACT_UNDERFLOW;
              end else begin
                mem_we = 1'b1;
                if (cmd.kind == scfp_pkg::CK_REALLOC) begin
                  res.action     = scfp_pkg::ACT_MOVE;
                  res.copy_bytes = scfp_pkg::CLS_BYTES[k];
                end else begin
                  res.action = scfp_pkg::ACT_RELEASED;
                end
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      B_READ: begin
        load                = 1'b1;
        res.action          = scfp_pkg::ACT_GRANTED;
        res.class_index     = rd_cls;
        res.slot_index      = gslot_x[9:0];
        res.granted_address = pool_base +
                              64'(scfp_pkg::region_off(int'(rd_cls), SLOTS_PER_CLASS)) +
                              64'(gprod);
      end
      default: load = 1'b0;
    endcase
  end

  // Update ring pointers and live counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      wrapped <= '0;
      for (int i = 0; i < scfp_pkg::CLASS_COUNT; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        live[i] <= '0;
      end
    end else begin
      unique case (state)
        B_IDLE: begin
          if (fire && alloc_ok) begin
            head[k] <= (CNT_W'(h) == len_k - 1'b1) ? '0 : h + 1'b1;
            live[k] <= lv + 1'b1;
            rd_cls  <= k;
            rd_head <= h;
            rd_hit  <= wrapped[k] || (h < t);
            state   <= B_READ;
          end else if (fire && push_ok) begin
            if (CNT_W'(t) == len_k - 1'b1) begin
              tail[k]    <= '0;
              wrapped[k] <= 1'b1;
            end else begin
              tail[k] <= t + 1'b1;
            end
            live[k] <= lv - 1'b1;
          end
        end
        B_READ: state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res;
  end

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == B_READ |=> state == B_IDLE)
    else $error("ring read state lasted more than one cycle");

  a_read_out_free: assert property (@(posedge clk) disable iff (rst)
    state == B_READ |-> !out_valid)
    else $error("grant would overwrite a pending result");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    fire |-> state == B_IDLE && out_free)
    else $error("command taken while back end busy");

  a_no_ring_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("ring written and read in one cycle");

endmodule

/* design/size_class_slot_pool_allocator.sv */
// Size-class slot pool allocator.
// Input channel in_valid/in_ready/in_data carries one request (allocate, free
// or reallocate); output channel out_valid/out_ready/out_data returns exactly
// one result per request, in request order.
// Config: cfg_we writes cfg_data into register cfg_index (0 enable, 1 bypass,
// 2 pool base) in the same cycle; write only while no request is in flight.
// The front end classifies a request (size match or address-range search and
// a reciprocal divide for the slot number) and hands it through a two-entry
// command queue to the back end, which owns the free-slot rings.
// Flow: the front end takes a request only while idle and so holds one at a
// time; a free or reallocate adds its divide state. The back end adds a ring
// RAM read state for a grant and takes no command while in it.
// A use-system or exhausted answer passes neither extra state; every other
// result passes one of them.
// Reset (synchronous) empties the queue and result register, clears config,
// and puts every ring back to identity order at once through per-class fill
// marks; no clearing pass is needed.
// When the receiver stalls the result is held; the back end stops, the queue
// fills, and then in_ready drops.
module size_class_slot_pool_allocator #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  scfp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output scfp_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data
);

  logic           pool_enable;
  logic           pool_bypass;
  logic [63:0]    pool_base;

  logic           f_valid;
  logic           f_ready;
  scfp_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  scfp_pkg::cmd_t q_cmd;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_enable <= 1'b0;
      pool_bypass <= 1'b0;
      pool_base   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        scfp_pkg::CFG_ENABLE: pool_enable <= cfg_data[0];
        scfp_pkg::CFG_BYPASS: pool_bypass <= cfg_data[0];
        scfp_pkg::CFG_BASE:   pool_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  scfp_front #(.SLOTS_PER_CLASS(SLOTS_PER_CLASS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .pool_enable (pool_enable),
    .pool_bypass (pool_bypass),
    .pool_base   (pool_base),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  scfp_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  scfp_back #(.SLOTS_PER_CLASS(SLOTS_PER_CLASS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .pool_base (pool_base),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
